FILE: hw/rtl/v3a_pkg.sv
// v3a_pkg: shared types and constants for the vector3_alu block.
// Opcode codes, operation classes, iterative unit state and control structs.
// No dependencies.
package v3a_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [3:0] OPC_ADD   = 4'd0;
    localparam logic [3:0] OPC_SUB   = 4'd1;
    localparam logic [3:0] OPC_SCALE = 4'd2;
    localparam logic [3:0] OPC_DIV   = 4'd3;
    localparam logic [3:0] OPC_DOT   = 4'd4;
    localparam logic [3:0] OPC_CROSS = 4'd5;
    localparam logic [3:0] OPC_LENSQ = 4'd6;
    localparam logic [3:0] OPC_LEN   = 4'd7;
    localparam logic [3:0] OPC_NORM  = 4'd8;

    typedef enum logic [3:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_SCALE,
        CLS_DIV,
        CLS_DOT,
        CLS_CROSS,
        CLS_LENSQ,
        CLS_LEN,
        CLS_NORM,
        CLS_NONE
    } op_class_t;

    typedef enum logic [1:0] {
        IT_IDLE,
        IT_DIV,
        IT_ROOT,
        IT_DONE
    } iter_state_t;

    typedef struct packed {
        logic      start;
        logic      ack;
        op_class_t cls;
    } iter_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
        logic dz;
    } iter_sts_t;

endpackage

FILE: hw/rtl/v3a_front.sv
// v3a_front: input transfer, opcode classification and a two-entry queue.
// Depends on v3a_pkg.
module v3a_front #(
    parameter int W = v3a_pkg::WORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_opcode,
    input  logic signed [W-1:0] s_ax,
    input  logic signed [W-1:0] s_ay,
    input  logic signed [W-1:0] s_az,
    input  logic signed [W-1:0] s_bx,
    input  logic signed [W-1:0] s_by,
    input  logic signed [W-1:0] s_bz,
    input  logic signed [W-1:0] s_scalar,
    output logic                f_valid,
    output v3a_pkg::op_class_t  f_cls,
    output logic [7*W-1:0]      f_data,
    input  logic                f_pop
);
    import v3a_pkg::*;

    op_class_t      cls_in;
    op_class_t      q_cls_reg [2];
    logic [7*W-1:0] q_data_reg [2];
    logic [1:0]     count_reg, count_next;
    logic           wr_ptr_reg, rd_ptr_reg;
    logic           push, pop;

    always_comb begin
        case (s_opcode)
            OPC_ADD:   cls_in = CLS_ADD;
            OPC_SUB:   cls_in = CLS_SUB;
            OPC_SCALE: cls_in = CLS_SCALE;
            OPC_DIV:   cls_in = CLS_DIV;
            OPC_DOT:   cls_in = CLS_DOT;
            OPC_CROSS: cls_in = CLS_CROSS;
            OPC_LENSQ: cls_in = CLS_LENSQ;
            OPC_LEN:   cls_in = CLS_LEN;
            OPC_NORM:  cls_in = CLS_NORM;
            default:   cls_in = CLS_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign f_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = f_pop && f_valid;
    assign f_cls   = q_cls_reg[rd_ptr_reg];
    assign f_data  = q_data_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_cls_reg[wr_ptr_reg]  <= cls_in;
            q_data_reg[wr_ptr_reg] <= {s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_scalar};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/v3a_iter.sv
// v3a_iter: iterative divide and square-root unit, three lanes.
// Serves divide, length and normalize one bit of quotient or root per cycle.
// Depends on v3a_pkg.
module v3a_iter #(
    parameter int W = v3a_pkg::WORD_BITS_DEF,
    parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  v3a_pkg::iter_ctl_t    ctl,
    input  logic signed [W-1:0]   a [3],
    input  logic signed [W-1:0]   s,
    input  logic [2*W-1:0]        sq [3],
    input  logic [2*W-1:0]        ssum,
    output v3a_pkg::iter_sts_t    sts,
    output logic signed [W-1:0]   r [3],
    output logic signed [W-1:0]   rs
);
    import v3a_pkg::*;

    localparam int XW = W + F;
    localparam int RW = 2 * W;
    localparam int CW = $clog2(XW + 1);
    localparam logic [XW-1:0] LIMP = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [XW-1:0] LIMN = {{(XW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    iter_state_t   state_reg, state_next;
    op_class_t     cls_reg;
    logic [CW-1:0] cnt_reg;
    logic          zero_reg;
    logic [RW-1:0] d_reg;
    logic [RW-1:0] rem_reg [3];
    logic [XW-1:0] num_reg [3];
    logic [XW-1:0] quo_reg [3];
    logic          neg_reg [3];
    logic [RW-1:0] rad_reg [3];
    logic [W-1:0]  root_reg [3];
    logic [W+1:0]  srem_reg [3];

    logic [W-1:0]  sm;
    logic [W-1:0]  am [3];
    logic [RW:0]   dt [3];
    logic          dge [3];
    logic [RW-1:0] drem [3];
    logic [XW-1:0] dquo [3];
    logic [W+3:0]  st [3];
    logic [W+3:0]  trial [3];
    logic          sge [3];
    logic [W+1:0]  srem_n [3];
    logic [W-1:0]  root_n [3];
    logic          last;
    logic          vec_ok;
    logic [W:0]    sat_v [3];
    logic [W:0]    sat_s;

    function automatic logic [W:0] sat_mag(input logic [XW-1:0] mag, input logic neg);
        logic [W:0] res;
        if (!neg) begin
            if (mag > LIMP) begin
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                res = {1'b0, mag[W-1:0]};
            end
        end else begin
            if (mag > LIMN) begin
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                res = {1'b0, W'(-mag[W-1:0])};
            end
        end
        return res;
    endfunction

    // Magnitudes; the most negative word maps to 2^(W-1) unchanged.
    always_comb begin
        sm = s[W-1] ? W'(-s) : s;
        for (int i = 0; i < 3; i++) begin
            am[i] = a[i][W-1] ? W'(-a[i]) : a[i];
        end
    end

    // One restoring divide step and one square-root step per lane.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dt[i]     = {rem_reg[i], num_reg[i][XW-1]};
            dge[i]    = (dt[i] >= {1'b0, d_reg});
            drem[i]   = dge[i] ? RW'(dt[i] - {1'b0, d_reg}) : dt[i][RW-1:0];
            dquo[i]   = {quo_reg[i][XW-2:0], dge[i]};
            st[i]     = {srem_reg[i], rad_reg[i][RW-1 -: 2]};
            trial[i]  = (W+4)'({root_reg[i], 2'b01});
            sge[i]    = (st[i] >= trial[i]);
            srem_n[i] = sge[i] ? (W+2)'(st[i] - trial[i]) : st[i][W+1:0];
            root_n[i] = {root_reg[i][W-2:0], sge[i]};
        end
    end

    assign last = (cnt_reg == CW'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            IT_IDLE: begin
                if (ctl.start) begin
                    case (ctl.cls)
                        CLS_DIV:  state_next = (sm == '0) ? IT_DONE : IT_DIV;
                        CLS_NORM: state_next = (ssum == '0) ? IT_DONE : IT_DIV;
                        CLS_LEN:  state_next = IT_ROOT;
                        default:  state_next = IT_IDLE;
                    endcase
                end
            end
            IT_DIV: begin
                if (last) begin
                    state_next = (cls_reg == CLS_NORM) ? IT_ROOT : IT_DONE;
                end
            end
            IT_ROOT: begin
                if (last) begin
                    state_next = IT_DONE;
                end
            end
            IT_DONE: begin
                if (ctl.ack) begin
                    state_next = IT_IDLE;
                end
            end
            default: state_next = IT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            IT_IDLE: begin
                if (ctl.start) begin
                    cls_reg  <= ctl.cls;
                    d_reg    <= (ctl.cls == CLS_NORM) ? ssum : RW'(sm);
                    zero_reg <= ((ctl.cls == CLS_DIV) && (sm == '0)) ||
                                ((ctl.cls == CLS_NORM) && (ssum == '0));
                    if (ctl.cls == CLS_DIV) begin
                        cnt_reg <= CW'(XW);
                    end else if (ctl.cls == CLS_NORM) begin
                        cnt_reg <= CW'(2 * F + 1);
                    end else begin
                        cnt_reg <= CW'(W);
                    end
                    for (int i = 0; i < 3; i++) begin
                        // normalize: quotient < 2^(2F+1), so start from sq/2 as remainder
                        if (ctl.cls == CLS_NORM) begin
                            rem_reg[i] <= sq[i] >> 1;
                            num_reg[i] <= {sq[i][0], {(XW-1){1'b0}}};
                            neg_reg[i] <= a[i][W-1];
                        end else begin
                            rem_reg[i] <= '0;
                            num_reg[i] <= {am[i], {F{1'b0}}};
                            neg_reg[i] <= a[i][W-1] ^ s[W-1];
                        end
                        quo_reg[i]  <= '0;
                        rad_reg[i]  <= (i == 0) ? ssum : '0;
                        root_reg[i] <= '0;
                        srem_reg[i] <= '0;
                    end
                end
            end
            IT_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[i] <= drem[i];
                    num_reg[i] <= {num_reg[i][XW-2:0], 1'b0};
                    quo_reg[i] <= dquo[i];
                end
                if (last) begin
                    cnt_reg <= CW'(W);
                    for (int i = 0; i < 3; i++) begin
                        rad_reg[i]  <= RW'(dquo[i]);
                        root_reg[i] <= '0;
                        srem_reg[i] <= '0;
                    end
                end else begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
            IT_ROOT: begin
                cnt_reg <= cnt_reg - CW'(1);
                for (int i = 0; i < 3; i++) begin
                    srem_reg[i] <= srem_n[i];
                    root_reg[i] <= root_n[i];
                    rad_reg[i]  <= {rad_reg[i][RW-3:0], 2'b00};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        vec_ok = ((cls_reg == CLS_DIV) || (cls_reg == CLS_NORM)) && !zero_reg;
        for (int i = 0; i < 3; i++) begin
            sat_v[i] = sat_mag((cls_reg == CLS_DIV) ? quo_reg[i] : XW'(root_reg[i]),
                               neg_reg[i]);
            r[i]     = vec_ok ? sat_v[i][W-1:0] : '0;
        end
        sat_s    = sat_mag(XW'(root_reg[0]), 1'b0);
        rs       = (cls_reg == CLS_LEN) ? sat_s[W-1:0] : '0;
        sts.done = (state_reg == IT_DONE);
        sts.dz   = zero_reg;
        sts.ovf  = (vec_ok && (sat_v[0][W] || sat_v[1][W] || sat_v[2][W])) ||
                   ((cls_reg == CLS_LEN) && sat_s[W]);
    end

endmodule

FILE: hw/rtl/v3a_back.sv
// v3a_back: execution pipeline (multiply, sum, truncate/saturate) and output register.
// Divide, length and normalize finish in the iterative unit. Depends on v3a_pkg, v3a_iter.
module v3a_back #(
    parameter int W = v3a_pkg::WORD_BITS_DEF,
    parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                f_valid,
    input  v3a_pkg::op_class_t  f_cls,
    input  logic [7*W-1:0]      f_data,
    output logic                f_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [W-1:0] m_rx,
    output logic signed [W-1:0] m_ry,
    output logic signed [W-1:0] m_rz,
    output logic signed [W-1:0] m_rscalar,
    output logic                m_overflow,
    output logic                m_div_zero
);
    import v3a_pkg::*;

    localparam int PW = 2 * W;
    localparam int VW = 2 * W + 2;
    localparam logic signed [VW-1:0] MAXV = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] MINV = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [VW-1:0] RND  = {{(VW-F){1'b0}}, {F{1'b1}}};

    logic signed [W-1:0]  in_a [3];
    logic signed [W-1:0]  in_b [3];
    logic signed [W-1:0]  in_s;
    logic signed [W-1:0]  ma [6];
    logic signed [W-1:0]  mb [6];
    logic signed [W:0]    as_sum [3];

    // multiply stage
    logic                 m_valid_reg;
    op_class_t            m_cls_reg;
    logic signed [PW-1:0] m_p_reg [6];
    logic signed [W:0]    m_sum_reg [3];
    logic signed [W-1:0]  m_a_reg [3];
    logic signed [W-1:0]  m_s_reg;

    // sum stage
    logic signed [VW-1:0] s_v [3];
    logic signed [VW-1:0] s_vs;
    logic                 s_valid_reg;
    op_class_t            s_cls_reg;
    logic signed [VW-1:0] s_v_reg [3];
    logic signed [VW-1:0] s_vs_reg;
    logic [PW-1:0]        s_sq_reg [3];
    logic signed [W-1:0]  s_a_reg [3];
    logic signed [W-1:0]  s_s_reg;

    // execute stage
    logic                 e_valid_reg;
    op_class_t            e_cls_reg;
    logic signed [VW-1:0] e_v_reg [3];
    logic signed [VW-1:0] e_vs_reg;
    logic [PW-1:0]        e_sq_reg [3];
    logic signed [W-1:0]  e_a_reg [3];
    logic signed [W-1:0]  e_s_reg;

    // output register
    logic                 o_valid_reg, o_valid_next;
    logic signed [W-1:0]  o_r_reg [3];
    logic signed [W-1:0]  o_rs_reg;
    logic                 o_ovf_reg;
    logic                 o_dz_reg;

    logic                 is_slow, is_vec, is_scal, sh_vec;
    logic                 e_fire, e_free;
    logic [W:0]           fv [3];
    logic [W:0]           fs;
    logic signed [W-1:0]  res_r [3];
    logic signed [W-1:0]  res_rs;
    logic                 res_ovf, res_dz;
    iter_ctl_t            it_ctl;
    iter_sts_t            it_sts;
    logic signed [W-1:0]  it_r [3];
    logic signed [W-1:0]  it_rs;

    // truncate toward zero after the optional fraction shift, then saturate
    function automatic logic [W:0] sat_sv(input logic signed [VW-1:0] x, input logic sh);
        logic signed [VW-1:0] t;
        logic [W:0]           res;
        if (sh) begin
            t = x[VW-1] ? ((x + RND) >>> F) : (x >>> F);
        end else begin
            t = x;
        end
        if (t > MAXV) begin
            res = {1'b1, MAXV[W-1:0]};
        end else if (t < MINV) begin
            res = {1'b1, MINV[W-1:0]};
        end else begin
            res = {1'b0, t[W-1:0]};
        end
        return res;
    endfunction

    assign in_a[0] = f_data[7*W-1 -: W];
    assign in_a[1] = f_data[6*W-1 -: W];
    assign in_a[2] = f_data[5*W-1 -: W];
    assign in_b[0] = f_data[4*W-1 -: W];
    assign in_b[1] = f_data[3*W-1 -: W];
    assign in_b[2] = f_data[2*W-1 -: W];
    assign in_s    = f_data[W-1:0];

    // operand routing onto six multipliers
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ma[i]     = in_a[i];
            mb[i]     = in_b[i];
            ma[i+3]   = '0;
            mb[i+3]   = '0;
            as_sum[i] = (f_cls == CLS_SUB) ? ((W+1)'(in_a[i]) - (W+1)'(in_b[i]))
                                           : ((W+1)'(in_a[i]) + (W+1)'(in_b[i]));
        end
        case (f_cls)
            CLS_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    mb[i] = in_s;
                end
            end
            CLS_CROSS: begin
                ma[0] = in_a[1]; mb[0] = in_b[2];
                ma[1] = in_a[2]; mb[1] = in_b[0];
                ma[2] = in_a[0]; mb[2] = in_b[1];
                ma[3] = in_a[2]; mb[3] = in_b[1];
                ma[4] = in_a[0]; mb[4] = in_b[2];
                ma[5] = in_a[1]; mb[5] = in_b[0];
            end
            CLS_LENSQ, CLS_LEN, CLS_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    mb[i] = in_a[i];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (m_cls_reg)
                CLS_ADD, CLS_SUB: s_v[i] = VW'(m_sum_reg[i]);
                CLS_SCALE:        s_v[i] = VW'(m_p_reg[i]);
                CLS_CROSS:        s_v[i] = VW'(m_p_reg[i]) - VW'(m_p_reg[i+3]);
                default:          s_v[i] = '0;
            endcase
        end
        s_vs = VW'(m_p_reg[0]) + VW'(m_p_reg[1]) + VW'(m_p_reg[2]);
    end

    always_comb begin
        is_slow = (e_cls_reg == CLS_DIV) || (e_cls_reg == CLS_LEN) || (e_cls_reg == CLS_NORM);
        is_vec  = (e_cls_reg == CLS_ADD) || (e_cls_reg == CLS_SUB) ||
                  (e_cls_reg == CLS_SCALE) || (e_cls_reg == CLS_CROSS);
        is_scal = (e_cls_reg == CLS_DOT) || (e_cls_reg == CLS_LENSQ);
        sh_vec  = (e_cls_reg == CLS_SCALE) || (e_cls_reg == CLS_CROSS);
        for (int i = 0; i < 3; i++) begin
            fv[i] = sat_sv(e_v_reg[i], sh_vec);
        end
        fs = sat_sv(e_vs_reg, 1'b1);
        if (is_slow) begin
            for (int i = 0; i < 3; i++) begin
                res_r[i] = it_r[i];
            end
            res_rs  = it_rs;
            res_ovf = it_sts.ovf;
            res_dz  = it_sts.dz;
        end else begin
            for (int i = 0; i < 3; i++) begin
                res_r[i] = is_vec ? fv[i][W-1:0] : '0;
            end
            res_rs  = is_scal ? fs[W-1:0] : '0;
            res_ovf = (is_vec && (fv[0][W] || fv[1][W] || fv[2][W])) || (is_scal && fs[W]);
            res_dz  = 1'b0;
        end
    end

    assign e_fire = e_valid_reg && (!is_slow || it_sts.done) && (!o_valid_reg || m_ready);
    assign e_free = !e_valid_reg || e_fire;
    assign f_pop  = e_free && f_valid;

    assign it_ctl.start = e_valid_reg && is_slow;
    assign it_ctl.ack   = e_fire && is_slow;
    assign it_ctl.cls   = e_cls_reg;

    v3a_iter #(
        .W(W),
        .F(F)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (it_ctl),
        .a       (e_a_reg),
        .s       (e_s_reg),
        .sq      (e_sq_reg),
        .ssum    (e_vs_reg[PW-1:0]),
        .sts     (it_sts),
        .r       (it_r),
        .rs      (it_rs)
    );

    always_comb begin
        o_valid_next = o_valid_reg;
        if (e_fire) begin
            o_valid_next = 1'b1;
        end else if (m_ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_free) begin
            m_cls_reg <= f_cls;
            for (int i = 0; i < 6; i++) begin
                m_p_reg[i] <= ma[i] * mb[i];
            end
            for (int i = 0; i < 3; i++) begin
                m_sum_reg[i] <= as_sum[i];
                m_a_reg[i]   <= in_a[i];
                s_v_reg[i]   <= s_v[i];
                s_sq_reg[i]  <= m_p_reg[i];
                s_a_reg[i]   <= m_a_reg[i];
                e_v_reg[i]   <= s_v_reg[i];
                e_sq_reg[i]  <= s_sq_reg[i];
                e_a_reg[i]   <= s_a_reg[i];
            end
            m_s_reg   <= in_s;
            s_cls_reg <= m_cls_reg;
            s_vs_reg  <= s_vs;
            s_s_reg   <= m_s_reg;
            e_cls_reg <= s_cls_reg;
            e_vs_reg  <= s_vs_reg;
            e_s_reg   <= s_s_reg;
        end
        if (e_fire) begin
            for (int i = 0; i < 3; i++) begin
                o_r_reg[i] <= res_r[i];
            end
            o_rs_reg  <= res_rs;
            o_ovf_reg <= res_ovf;
            o_dz_reg  <= res_dz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (e_free) begin
                m_valid_reg <= f_valid;
                s_valid_reg <= m_valid_reg;
                e_valid_reg <= s_valid_reg;
            end
            o_valid_reg <= o_valid_next;
        end
    end

    assign m_valid    = o_valid_reg;
    assign m_rx       = o_r_reg[0];
    assign m_ry       = o_r_reg[1];
    assign m_rz       = o_r_reg[2];
    assign m_rscalar  = o_rs_reg;
    assign m_overflow = o_ovf_reg;
    assign m_div_zero = o_dz_reg;

endmodule

FILE: hw/rtl/vector3_alu.sv
// vector3_alu: signed fixed-point three-component vector unit.
// Front queue and execution back end; uses v3a_pkg, v3a_front, v3a_back.
//
// Usage
//   Input channel s_*: opcode, vectors A and B, scalar, all WORD_BITS wide with
//   FRAC_BITS fraction bits. Result channel m_*: vector, scalar, overflow and
//   divide-by-zero flags. Both sides transfer on valid and ready high together.
//   Add, sub, scale, dot, cross and length squared pass from the queue
//   through the multiply, sum and execute stages, then the output register.
//   These ops sustain one transfer per cycle while the output is not stalled
//   and no slow op holds the execute stage. Divide, length and normalize
//   hold the execute stage while the iterative unit runs: a start step, one
//   bit of quotient or root per cycle, then a step to hand the result on;
//   normalize divides before it takes the root. A zero divisor or
//   zero-length normalize finishes without iterating.
//   Reset (aresetn low, synchronous) empties the queue and all pipeline stages.
//   When the receiver holds m_ready low the result stays in the output register,
//   the pipeline stalls behind it and the two-entry queue keeps accepting until
//   full, after which s_ready drops.
//   Unknown opcodes give an all-zero result with both flags clear.
module vector3_alu #(
    parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [3:0]                  s_opcode,
    input  logic signed [WORD_BITS-1:0] s_ax,
    input  logic signed [WORD_BITS-1:0] s_ay,
    input  logic signed [WORD_BITS-1:0] s_az,
    input  logic signed [WORD_BITS-1:0] s_bx,
    input  logic signed [WORD_BITS-1:0] s_by,
    input  logic signed [WORD_BITS-1:0] s_bz,
    input  logic signed [WORD_BITS-1:0] s_scalar,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_rx,
    output logic signed [WORD_BITS-1:0] m_ry,
    output logic signed [WORD_BITS-1:0] m_rz,
    output logic signed [WORD_BITS-1:0] m_rscalar,
    output logic                        m_overflow,
    output logic                        m_div_zero
);
    import v3a_pkg::*;

    // queue head towards the back end
    logic                   f_valid;
    op_class_t              f_cls;
    logic [7*WORD_BITS-1:0] f_data;
    logic                   f_pop;

    // front: transfer in, opcode decode, two-entry queue
    v3a_front #(
        .W(WORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_ax     (s_ax),
        .s_ay     (s_ay),
        .s_az     (s_az),
        .s_bx     (s_bx),
        .s_by     (s_by),
        .s_bz     (s_bz),
        .s_scalar (s_scalar),
        .f_valid  (f_valid),
        .f_cls    (f_cls),
        .f_data   (f_data),
        .f_pop    (f_pop)
    );

    // back: in-order pipeline; slow ops park in the execute stage
    v3a_back #(
        .W(WORD_BITS),
        .F(FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .f_valid    (f_valid),
        .f_cls      (f_cls),
        .f_data     (f_data),
        .f_pop      (f_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rx       (m_rx),
        .m_ry       (m_ry),
        .m_rz       (m_rz),
        .m_rscalar  (m_rscalar),
        .m_overflow (m_overflow),
        .m_div_zero (m_div_zero)
    );

endmodule

FILE: sim/v3a_checker.sv
// v3a_checker: watches both channels of vector3_alu, predicts every result
// exactly in wide integer arithmetic and compares it with what the block returns.
// Depends on v3a_pkg for the opcode codes.
`timescale 1ns / 1ps
module v3a_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by,
    input  logic signed [31:0] s_bz,
    input  logic signed [31:0] s_scalar,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_rx,
    input  logic signed [31:0] m_ry,
    input  logic signed [31:0] m_rz,
    input  logic signed [31:0] m_rscalar,
    input  logic               m_overflow,
    input  logic               m_div_zero,
    output int                 err_count,
    output int                 pending
);
    import v3a_pkg::*;

    typedef struct {
        logic [31:0] rx, ry, rz, rs;
        logic        ovf, dz;
    } vec_result_t;

    vec_result_t results_due[$];

    assign pending = results_due.size();

    // sign and magnitude of a wide signed value
    function automatic void split(input logic signed [127:0] v, output logic neg,
                                  output logic [127:0] mag);
        neg = v[127];
        mag = neg ? -v : v;
    endfunction

    // final value into a word: saturate, flag it
    function automatic logic [31:0] clamp_word(input logic neg, input logic [127:0] mag,
                                              inout logic ovf);
        if (!neg) begin
            if (mag > 128'h7fff_ffff) begin
                ovf = 1'b1;
                return 32'h7fff_ffff;
            end
            return mag[31:0];
        end
        if (mag > 128'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return -mag[31:0];
    endfunction

    // signed Q32-fraction product sum back to Q16.16, truncated toward zero
    function automatic logic [31:0] narrow_q(input logic signed [127:0] v, inout logic ovf);
        logic         neg;
        logic [127:0] mag;
        split(v, neg, mag);
        return clamp_word(neg, mag >> 16, ovf);
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] res, bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic vec_result_t predict_vec(input logic [3:0] op,
                                                input logic signed [31:0] va [3],
                                                input logic signed [31:0] vb [3],
                                                input logic signed [31:0] sc);
        vec_result_t          r;
        logic signed [127:0]  wa [3], wb [3], ws, acc;
        logic [127:0]         sq, mag, smag, q;
        logic                 neg, sneg;
        logic [31:0]          comp [3];
        int                   j, k;
        r = '{default: '0};
        comp = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            wa[i] = va[i];
            wb[i] = vb[i];
        end
        ws = sc;
        sq = wa[0] * wa[0] + wa[1] * wa[1] + wa[2] * wa[2];
        case (op)
            OPC_ADD, OPC_SUB, OPC_SCALE, OPC_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    if (op == OPC_ADD)
                        acc = (wa[i] + wb[i]) << 16;
                    else if (op == OPC_SUB)
                        acc = (wa[i] - wb[i]) << 16;
                    else if (op == OPC_SCALE)
                        acc = wa[i] * ws;
                    else
                        acc = wa[j] * wb[k] - wa[k] * wb[j];
                    comp[i] = narrow_q(acc, r.ovf);
                end
            end
            OPC_DIV: begin
                split(ws, sneg, smag);
                if (smag == 0) begin
                    r.dz = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        split(wa[i], neg, mag);
                        comp[i] = clamp_word(neg ^ sneg, (mag << 16) / smag, r.ovf);
                    end
                end
            end
            OPC_DOT: r.rs = narrow_q(wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2], r.ovf);
            OPC_LENSQ: r.rs = clamp_word(1'b0, sq >> 16, r.ovf);
            OPC_LEN: r.rs = clamp_word(1'b0, floor_sqrt(sq), r.ovf);
            OPC_NORM: begin
                if (sq == 0) begin
                    r.dz = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        split(wa[i], neg, mag);
                        q = ((mag * mag) << 32) / sq;
                        comp[i] = clamp_word(neg, floor_sqrt(q), r.ovf);
                    end
                end
            end
            default: ;   // unknown opcode: all zero
        endcase
        r.rx = comp[0];
        r.ry = comp[1];
        r.rz = comp[2];
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    always @(posedge aclk) begin
        logic signed [31:0] va [3], vb [3];
        vec_result_t        want;
        if (!aresetn) begin
            err_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                va = '{s_ax, s_ay, s_az};
                vb = '{s_bx, s_by, s_bz};
                results_due.push_back(predict_vec(s_opcode, va, vb, s_scalar));
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                end else begin
                    want = results_due.pop_front();
                    if (m_rx !== want.rx) note_mismatch("rx", want.rx, m_rx);
                    if (m_ry !== want.ry) note_mismatch("ry", want.ry, m_ry);
                    if (m_rz !== want.rz) note_mismatch("rz", want.rz, m_rz);
                    if (m_rscalar !== want.rs) note_mismatch("rscalar", want.rs, m_rscalar);
                    if (m_overflow !== want.ovf)
                        note_mismatch("overflow", 32'(want.ovf), 32'(m_overflow));
                    if (m_div_zero !== want.dz)
                        note_mismatch("div_zero", 32'(want.dz), 32'(m_div_zero));
                end
            end
        end
    end
endmodule

FILE: sim/tb_top.sv
// tb_top: stimulus and verdict for vector3_alu.
// Instantiates the block and v3a_checker; uses v3a_pkg opcode codes.
`timescale 1ns / 1ps
module tb_top;
    import v3a_pkg::*;

    localparam int WDOG_LIMIT = 4000;   // allows for the slowest op, with stalls on top

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_opcode = '0;
    logic signed [31:0] s_ax = '0, s_ay = '0, s_az = '0;
    logic signed [31:0] s_bx = '0, s_by = '0, s_bz = '0;
    logic signed [31:0] s_scalar = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_rx, m_ry, m_rz, m_rscalar;
    logic        m_overflow, m_div_zero;

    int err_count;
    int pending;
    int send_idle_pct = 0;   // chance of an idle cycle before each input transfer
    int recv_stall_pct = 0;  // chance of m_ready low in a cycle
    int quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    vector3_alu u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_ax      (s_ax),
        .s_ay      (s_ay),
        .s_az      (s_az),
        .s_bx      (s_bx),
        .s_by      (s_by),
        .s_bz      (s_bz),
        .s_scalar  (s_scalar),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rx      (m_rx),
        .m_ry      (m_ry),
        .m_rz      (m_rz),
        .m_rscalar (m_rscalar),
        .m_overflow(m_overflow),
        .m_div_zero(m_div_zero)
    );

    v3a_checker u_checker (.*);

    // receiver: random back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: too long without any transfer on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input transfer; valid stays high across back-to-back items
    task automatic send_op(input logic [3:0] op,
                           input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                           input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_ax <= ax; s_ay <= ay; s_az <= az;
        s_bx <= bx; s_by <= by; s_bz <= bz;
        s_scalar <= sc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // word mix: extremes, units, small values, full random
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
            4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(input int count);
        logic [3:0] op;
        for (int n = 0; n < count; n++) begin
            // mostly legal opcodes, a few unknown ones
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                           : 4'($urandom_range(8));
            if (op == OPC_NORM && $urandom_range(9) == 0)
                send_op(op, '0, '0, '0, pick_word(), pick_word(), pick_word(), pick_word());
            else if (op == OPC_DIV && $urandom_range(9) == 0)
                send_op(op, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                        pick_word(), '0);
            else
                send_op(op, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                        pick_word(), pick_word());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every op at the extremes, zero divisor, zero-length normalise,
        // zero-length length, unknown opcodes
        send_op(OPC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1, 32'h8000_0000,
                32'hffff_ffff, '0);
        send_op(OPC_SUB, 32'h8000_0000, 32'h7fff_ffff, '0, 32'h1, 32'hffff_ffff,
                32'h8000_0000, '0);
        send_op(OPC_SCALE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_8000, '0, '0, '0,
                32'h8000_0000);
        send_op(OPC_SCALE, 32'h0003_0000, 32'hfffe_8000, 32'h1, '0, '0, '0, 32'h0000_8000);
        send_op(OPC_DIV, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, '0, '0, '0, '0);
        send_op(OPC_DIV, 32'h8000_0000, 32'h0001_0000, 32'hffff_fffd, '0, '0, '0, 32'h1);
        send_op(OPC_DIV, 32'h0005_0000, 32'hfffb_0000, 32'h7, '0, '0, '0, 32'h8000_0000);
        send_op(OPC_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, '0);
        send_op(OPC_DOT, 32'h0002_0000, 32'hffff_0000, 32'h1, 32'h0003_0000, 32'h0004_0000,
                32'hffff_ffff, '0);
        send_op(OPC_CROSS, 32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0, '0);
        send_op(OPC_CROSS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, '0);
        send_op(OPC_LENSQ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0);
        send_op(OPC_LENSQ, '0, '0, '0, '0, '0, '0, '0);
        send_op(OPC_LEN, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, '0);
        send_op(OPC_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0);
        send_op(OPC_LEN, '0, '0, '0, '0, '0, '0, '0);
        send_op(OPC_NORM, 32'h0003_0000, 32'hfffc_0000, '0, '0, '0, '0, '0);
        send_op(OPC_NORM, 32'h8000_0000, 32'h1, 32'h7fff_ffff, '0, '0, '0, '0);
        send_op(OPC_NORM, 32'h0, 32'h0, 32'hffff_ffff, '0, '0, '0, '0);
        send_op(OPC_NORM, '0, '0, '0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff);
        send_op(4'd9, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_op(4'd15, 32'h0001_0000, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);

        // random phases: free flow, idle sender, stalling receiver, both
        random_items(425);
        send_idle_pct = 49;
        random_items(425);

        // hold off until the pipeline has drained, then resume
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        send_idle_pct = 0;
        recv_stall_pct = 49;
        random_items(425);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        random_items(425);
        s_valid <= 1'b0;

        // drain, then allow for the slowest op still in flight
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
